### rtl/assert_macros.svh
// Assertion shorthands for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/drs_pkg.sv
package drs_pkg;

    localparam int QUEUE_DEPTH  = 32;
    localparam int ADDRESS_BITS = 16;
    localparam int TAG_BITS     = 8;
    localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int POLICY_BITS  = 3;
    localparam int STATUS_BITS  = 2;
    localparam int WORD_BITS    = ADDRESS_BITS + TAG_BITS;

    typedef logic [IDX_BITS-1:0]     idx_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;
    typedef logic [ADDRESS_BITS-1:0] addr_t;
    typedef logic [TAG_BITS-1:0]     tag_t;
    typedef logic [POLICY_BITS-1:0]  policy_t;
    typedef logic [STATUS_BITS-1:0]  status_t;

    localparam policy_t POL_FIFO  = 3'd0;
    localparam policy_t POL_SSTF  = 3'd1;
    localparam policy_t POL_LOOK  = 3'd2;
    localparam policy_t POL_CLOOK = 3'd3;
    localparam policy_t POL_FLOOK = 3'd4;

    localparam status_t STATUS_ADDED    = 2'd0;
    localparam status_t STATUS_REJECTED = 2'd1;
    localparam status_t STATUS_GRANTED  = 2'd2;
    localparam status_t STATUS_NOTHING  = 2'd3;

    typedef struct packed {
        logic  mode;
        addr_t req_address;
        tag_t  req_tag;
    } item_t;

    typedef struct packed {
        status_t status;
        tag_t    grant_tag;
        addr_t   grant_address;
        addr_t   seek_distance;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_PICK,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_GRANT
    } state_t;

    typedef enum logic [2:0] {
        KIND_OLDEST,
        KIND_NEAREST,
        KIND_UP,
        KIND_DOWN,
        KIND_LOWEST
    } kind_t;

    typedef enum logic [1:0] {
        FB_NONE,
        FB_REVERSE,
        FB_LOWEST
    } fallback_t;

    // sequencer to compare unit
    typedef struct packed {
        logic  clear;
        logic  en;
        logic  elig;
        kind_t kind;
    } scan_ctl_t;

    // best candidate so far
    typedef struct packed {
        logic  found;
        idx_t  idx;
        addr_t addr;
        tag_t  tag;
        idx_t  age;
        addr_t seek;
    } scan_best_t;

endpackage

### rtl/disk_request_scheduler.sv
// Channel  Handshake              Word        Notes
// item     start / busy           item_t      taken when start high, busy low
// result   done (strobe)          result_t    valid for the done cycle only
// config   cfg_valid / cfg_ready  cfg_data    policy register, ready always high
//
// Add: ST_ADD writes the table unless full and registers done. Pick: one
// read-and-compare sweep of the table through the single RAM read port and
// compare unit, ST_SCAN to ST_DECIDE; LOOK, FLOOK and CLOOK take a second sweep
// when the first direction holds nothing. Empty pick: done from ST_PICK.
// rst_n clears valid bits, head, sweep, active set, count at once; no clearing
// pass. The result strobe cannot be held off, so nothing waits on the receiver.
module disk_request_scheduler (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  drs_pkg::item_t            item,
    output logic                      done,
    output drs_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  drs_pkg::policy_t          cfg_data
);

    import drs_pkg::*;

    // sequencer
    state_t    state_reg, state_next;
    item_t     item_reg;
    kind_t     kind_reg, kind_next;
    fallback_t fb_reg, fb_next;
    logic      by_set_reg, by_set_next;
    logic      set_sel_reg, set_sel_next;
    idx_t      issue_reg, issue_next;
    logic      dvld_reg, dvld_next;
    idx_t      didx_reg, didx_next;
    logic      done_reg, done_next;
    result_t   result_reg, result_next;

    // table and disk state
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [QUEUE_DEPTH-1:0] set_reg, set_next;
    idx_t                   age_reg [QUEUE_DEPTH];
    idx_t                   age_next [QUEUE_DEPTH];
    addr_t                  head_reg, head_next;
    logic                   sweep_reg, sweep_next;
    logic                   active_reg, active_next;
    cnt_t                   count_reg, count_next;
    policy_t                policy_reg;

    // helpers
    idx_t       free_idx;
    logic       full;
    logic       any_valid;
    logic       active_has;
    logic       act_eff;
    scan_ctl_t  scan_ctl;
    scan_best_t best;
    logic [WORD_BITS-1:0] ram_rdata;
    logic                 ram_we;

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // lowest free slot; full when every slot is taken
    always_comb
    begin
        free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_BITS'(i);
            end
        end
    end

    assign full       = &valid_reg;
    assign any_valid  = |valid_reg;
    assign active_has = |(valid_reg & ~(set_reg ^ {QUEUE_DEPTH{active_reg}}));
    // FLOOK swaps to the other set once the active one runs dry
    assign act_eff    = active_has ? active_reg : ~active_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = item.mode ? ST_PICK : ST_ADD;
                end
            end
            ST_ADD:    state_next = ST_IDLE;
            ST_PICK:   state_next = any_valid ? ST_SCAN : ST_IDLE;
            ST_SCAN:
            begin
                if (issue_reg == IDX_BITS'(QUEUE_DEPTH - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (best.found)
                begin
                    state_next = ST_GRANT;
                end
                else if (fb_reg != FB_NONE)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_GRANT:  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next    = kind_reg;
        fb_next      = fb_reg;
        by_set_next  = by_set_reg;
        set_sel_next = set_sel_reg;
        issue_next   = issue_reg;
        dvld_next    = 1'b0;
        didx_next    = didx_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        valid_next   = valid_reg;
        set_next     = set_reg;
        age_next     = age_reg;
        head_next    = head_reg;
        sweep_next   = sweep_reg;
        active_next  = active_reg;
        count_next   = count_reg;
        ram_we       = 1'b0;

        scan_ctl.clear = (state_reg == ST_PICK) || (state_reg == ST_DECIDE);
        scan_ctl.en    = dvld_reg;
        scan_ctl.elig  = valid_reg[didx_reg] &&
                         (!by_set_reg || (set_reg[didx_reg] == set_sel_reg));
        scan_ctl.kind  = kind_reg;

        unique case (state_reg)
            ST_ADD:
            begin
                done_next   = 1'b1;
                result_next = '0;
                if (full)
                begin
                    result_next.status = STATUS_REJECTED;
                end
                else
                begin
                    result_next.status  = STATUS_ADDED;
                    ram_we              = 1'b1;
                    valid_next[free_idx] = 1'b1;
                    set_next[free_idx]   = ~active_reg;
                    age_next[free_idx]   = count_reg[IDX_BITS-1:0];
                    count_next           = count_reg + 1'b1;
                end
            end
            ST_PICK:
            begin
                issue_next   = '0;
                by_set_next  = 1'b0;
                set_sel_next = active_reg;
                fb_next      = FB_NONE;
                unique case (policy_reg)
                    POL_SSTF:  kind_next = KIND_NEAREST;
                    POL_LOOK:
                    begin
                        kind_next = sweep_reg ? KIND_UP : KIND_DOWN;
                        fb_next   = FB_REVERSE;
                    end
                    POL_CLOOK:
                    begin
                        kind_next = KIND_UP;
                        fb_next   = FB_LOWEST;
                    end
                    POL_FLOOK:
                    begin
                        kind_next    = sweep_reg ? KIND_UP : KIND_DOWN;
                        fb_next      = FB_REVERSE;
                        by_set_next  = 1'b1;
                        set_sel_next = act_eff;
                        if (any_valid)
                        begin
                            active_next = act_eff;
                        end
                    end
                    default:   kind_next = KIND_OLDEST;
                endcase
                if (!any_valid)
                begin
                    done_next          = 1'b1;
                    result_next        = '0;
                    result_next.status = STATUS_NOTHING;
                end
            end
            ST_SCAN:
            begin
                issue_next = issue_reg + 1'b1;
                dvld_next  = 1'b1;
                didx_next  = issue_reg;
            end
            ST_DECIDE:
            begin
                issue_next = '0;
                if (!best.found)
                begin
                    case (fb_reg)
                        FB_REVERSE:
                        begin
                            // sweep side empty: turn round and go again
                            sweep_next = ~sweep_reg;
                            kind_next  = sweep_reg ? KIND_DOWN : KIND_UP;
                            fb_next    = FB_NONE;
                        end
                        FB_LOWEST:
                        begin
                            // nothing at or above the head: wrap to the lowest
                            kind_next = KIND_LOWEST;
                            fb_next   = FB_NONE;
                        end
                        default:
                        begin
                            done_next          = 1'b1;
                            result_next        = '0;
                            result_next.status = STATUS_NOTHING;
                        end
                    endcase
                end
            end
            ST_GRANT:
            begin
                done_next                 = 1'b1;
                result_next.status        = STATUS_GRANTED;
                result_next.grant_tag     = best.tag;
                result_next.grant_address = best.addr;
                result_next.seek_distance = best.seek;
                head_next                 = best.addr;
                valid_next[best.idx]      = 1'b0;
                count_next                = count_reg - 1'b1;
                // close the rank gap left by the granted entry
                for (int i = 0; i < QUEUE_DEPTH; i++)
                begin
                    if (valid_reg[i] && (age_reg[i] > best.age))
                    begin
                        age_next[i] = age_reg[i] - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dvld_reg   <= 1'b0;
            done_reg   <= 1'b0;
            valid_reg  <= '0;
            head_reg   <= '0;
            sweep_reg  <= 1'b1;
            active_reg <= 1'b0;
            count_reg  <= '0;
            policy_reg <= POL_FIFO;
        end
        else
        begin
            state_reg  <= state_next;
            dvld_reg   <= dvld_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            head_reg   <= head_next;
            sweep_reg  <= sweep_next;
            active_reg <= active_next;
            count_reg  <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        kind_reg    <= kind_next;
        fb_reg      <= fb_next;
        by_set_reg  <= by_set_next;
        set_sel_reg <= set_sel_next;
        issue_reg   <= issue_next;
        didx_reg    <= didx_next;
        result_reg  <= result_next;
        set_reg     <= set_next;
        age_reg     <= age_next;
    end

    drs_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata ({item_reg.req_address, item_reg.req_tag}),
        .raddr (issue_reg),
        .rdata (ram_rdata)
    );

    drs_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .head       (head_reg),
        .entry_idx  (didx_reg),
        .entry_addr (ram_rdata[WORD_BITS-1:TAG_BITS]),
        .entry_tag  (ram_rdata[TAG_BITS-1:0]),
        .entry_age  (age_reg[didx_reg]),
        .best       (best)
    );

endmodule

### rtl/drs_ram.sv
module drs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/drs_scan.sv
module drs_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  drs_pkg::scan_ctl_t   ctl,
    input  drs_pkg::addr_t       head,
    input  drs_pkg::idx_t        entry_idx,
    input  drs_pkg::addr_t       entry_addr,
    input  drs_pkg::tag_t        entry_tag,
    input  drs_pkg::idx_t        entry_age,
    output drs_pkg::scan_best_t  best
);

    import drs_pkg::*;

    logic  found_reg, found_next;
    idx_t  best_idx_reg;
    addr_t best_addr_reg;
    tag_t  best_tag_reg;
    idx_t  best_age_reg;
    addr_t best_seek_reg;
    addr_t key_reg;

    logic  ge;
    logic  pass;
    logic  take;
    addr_t diff;
    addr_t key;

    // one subtract, one key compare per entry
    always_comb
    begin
        ge   = (entry_addr >= head);
        diff = ge ? (entry_addr - head) : (head - entry_addr);
        case (ctl.kind)
            KIND_UP:   pass = ge;
            KIND_DOWN: pass = (entry_addr <= head);
            default:   pass = 1'b1;
        endcase
        case (ctl.kind)
            KIND_OLDEST: key = '0;
            KIND_LOWEST: key = entry_addr;
            default:     key = diff;
        endcase
        take = ctl.en && ctl.elig && pass &&
               (!found_reg || (key < key_reg) ||
                ((key == key_reg) && (entry_age < best_age_reg)));
        found_next = ctl.clear ? 1'b0 : (found_reg || take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            key_reg       <= key;
            best_idx_reg  <= entry_idx;
            best_addr_reg <= entry_addr;
            best_tag_reg  <= entry_tag;
            best_age_reg  <= entry_age;
            best_seek_reg <= diff;
        end
    end

    always_comb
    begin
        best.found = found_reg;
        best.idx   = best_idx_reg;
        best.addr  = best_addr_reg;
        best.tag   = best_tag_reg;
        best.age   = best_age_reg;
        best.seek  = best_seek_reg;
    end

endmodule

### rtl/drs_checker.sv
`include "assert_macros.svh"

module drs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input drs_pkg::item_t    item,
    input logic              done,
    input drs_pkg::result_t  result
);

    import drs_pkg::*;

    logic take_item;
    logic add_taken;
    logic no_grant;
    logic fields_clear;

    assign take_item    = start && !busy;
    assign add_taken    = take_item && !item.mode;
    assign no_grant     = done && (result.status != STATUS_GRANTED);
    assign fields_clear = (result.grant_tag == '0) && (result.grant_address == '0) &&
                          (result.seek_distance == '0);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, take_item, busy, "no busy after accept")
    `ASSERT_IMPLY(a_idle_on_done, clk, rst_n, done, !busy, "result shown while busy")
    `ASSERT_NEXT(a_single_strobe, clk, rst_n, done, !done, "result strobe held")
    `ASSERT_IMPLY(a_add_latency, clk, rst_n, add_taken, ##2 done, "add late")
    `ASSERT_IMPLY(a_zero_fields, clk, rst_n, no_grant, fields_clear, "stale grant fields")

endmodule

bind disk_request_scheduler drs_checker u_drs_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import drs_pkg::*;

    // Request word mode bit
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_PICK = 1'b1;

    // Policy codes with no scheduler of their own; they fall back to FIFO
    localparam policy_t POL_SPARE5 = 3'd5;
    localparam policy_t POL_SPARE6 = 3'd6;
    localparam policy_t POL_SPARE7 = 3'd7;

    localparam int ITEM_TARGET   = 1100;
    // Slowest word is a two-sweep pick; pad generously
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 17;
    // Quiet cycles before the watchdog gives up: far beyond a long gap plus a slow pick
    localparam int IDLE_LIMIT    = 4000;

    logic    clk;
    logic    rst_n     = 1'b0;
    logic    start     = 1'b0;
    logic    busy;
    item_t   item      = '0;
    logic    done;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    policy_t cfg_data  = POL_FIFO;

    // Scoreboard: mirrors the request table, predicts one result word per
    // accepted request word and checks the result words in order.
    class grant_scoreboard;
        addr_t       slot_addr [QUEUE_DEPTH];
        tag_t        slot_tag  [QUEUE_DEPTH];
        int unsigned slot_rank [QUEUE_DEPTH];
        bit          slot_live [QUEUE_DEPTH];
        bit          slot_set  [QUEUE_DEPTH];
        addr_t       head;
        bit          going_up;
        bit          live_set;
        int unsigned pending_count;
        policy_t     pol;
        result_t     due_results [$];
        int unsigned mismatches;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            head          = '0;
            going_up      = 1'b1;
            live_set      = 1'b0;
            pending_count = 0;
            pol           = POL_FIFO;
            mismatches    = 0;
        endfunction

        function void set_policy(policy_t p);
            pol = p;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function addr_t gap_to(addr_t a);
            return (a >= head) ? a - head : head - a;
        endfunction

        // Best live slot of one kind; ties go to the lowest arrival rank
        function int find_best(kind_t kind, bit by_set, bit which);
            int          best;
            addr_t       best_key;
            int unsigned best_rank;
            addr_t       key;
            best      = -1;
            best_key  = '0;
            best_rank = 0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (!slot_live[i]) continue;
                if (by_set && slot_set[i] != which) continue;
                if (kind == KIND_UP && slot_addr[i] < head) continue;
                if (kind == KIND_DOWN && slot_addr[i] > head) continue;
                if (kind == KIND_OLDEST) key = '0;
                else if (kind == KIND_LOWEST) key = slot_addr[i];
                else key = gap_to(slot_addr[i]);
                if (best < 0 || key < best_key ||
                    (key == best_key && slot_rank[i] < best_rank))
                begin
                    best      = i;
                    best_key  = key;
                    best_rank = slot_rank[i];
                end
            end
            return best;
        endfunction

        // Elevator sweep; turns round when nothing lies ahead
        function int sweep_pick(bit by_set, bit which);
            int idx;
            idx = find_best(going_up ? KIND_UP : KIND_DOWN, by_set, which);
            if (idx < 0 && find_best(KIND_OLDEST, by_set, which) >= 0)
            begin
                going_up = !going_up;
                idx = find_best(going_up ? KIND_UP : KIND_DOWN, by_set, which);
            end
            return idx;
        endfunction

        function void note_request(item_t it);
            result_t r;
            int      idx;
            r   = '0;
            idx = -1;
            if (it.mode == MODE_ADD)
            begin
                for (int i = 0; i < QUEUE_DEPTH; i++)
                    if (!slot_live[i] && idx < 0) idx = i;
                if (idx < 0)
                begin
                    r.status = STATUS_REJECTED;
                end
                else
                begin
                    slot_addr[idx] = it.req_address;
                    slot_tag[idx]  = it.req_tag;
                    slot_rank[idx] = pending_count;
                    slot_set[idx]  = !live_set;
                    slot_live[idx] = 1'b1;
                    pending_count++;
                    r.status = STATUS_ADDED;
                end
            end
            else if (find_best(KIND_OLDEST, 1'b0, 1'b0) < 0)
            begin
                r.status = STATUS_NOTHING;
            end
            else
            begin
                case (pol)
                    POL_SSTF:  idx = find_best(KIND_NEAREST, 1'b0, 1'b0);
                    POL_LOOK:  idx = sweep_pick(1'b0, 1'b0);
                    POL_CLOOK:
                    begin
                        idx = find_best(KIND_UP, 1'b0, 1'b0);
                        if (idx < 0) idx = find_best(KIND_LOWEST, 1'b0, 1'b0);
                    end
                    POL_FLOOK:
                    begin
                        if (find_best(KIND_OLDEST, 1'b1, live_set) < 0)
                            live_set = !live_set;
                        idx = sweep_pick(1'b1, live_set);
                    end
                    default:   idx = find_best(KIND_OLDEST, 1'b0, 1'b0);
                endcase
                if (idx < 0)
                begin
                    r.status = STATUS_NOTHING;
                end
                else
                begin
                    r.status        = STATUS_GRANTED;
                    r.grant_tag     = slot_tag[idx];
                    r.grant_address = slot_addr[idx];
                    r.seek_distance = gap_to(slot_addr[idx]);
                    head            = slot_addr[idx];
                    slot_live[idx]  = 1'b0;
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                        if (slot_live[i] && slot_rank[i] > slot_rank[idx]) slot_rank[i]--;
                    if (pending_count > 0) pending_count--;
                end
            end
            due_results = {due_results, r};
        endfunction

        function void note_miss(string why, result_t want, result_t got);
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("%s: want st %0d tag %02h addr %04h seek %04h,",
                       why, want.status, want.grant_tag, want.grant_address,
                       want.seek_distance);
                $display(" got st %0d tag %02h addr %04h seek %04h",
                         got.status, got.grant_tag, got.grant_address,
                         got.seek_distance);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (due_results.size() == 0)
            begin
                note_miss("result word with nothing outstanding", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.grant_tag !== want.grant_tag ||
                got.grant_address !== want.grant_address ||
                got.seek_distance !== want.seek_distance)
                note_miss("result word differs", want, got);
        endfunction
    endclass

    grant_scoreboard sb = new();
    int              requests_sent = 0;
    int              quiet_cycles  = 0;
    policy_t         phase_policy [8] = '{POL_FIFO, POL_SSTF, POL_LOOK, POL_CLOOK,
                                          POL_FLOOK, POL_SPARE5, POL_SPARE6, POL_SPARE7};

    disk_request_scheduler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor: samples at the rising edge, before the block's own updates land.
    // Result word first, so a result and a new request in the same cycle pair up right.
    // Also the watchdog: any handshake counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result(result);
            if (cfg_valid && cfg_ready) sb.set_policy(cfg_data);
            if (start && !busy) sb.note_request(item);
            if (done || (cfg_valid && cfg_ready) || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("disk_request_scheduler: mismatch");
                $finish;
            end
        end
    end

    // Gap length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Addresses: extremes, a tight cluster (ties and short seeks), or anything
    function automatic addr_t pick_address();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'h0001;
                default: return 16'hFFFE;
            endcase
        end
        if (r < 5) return 16'h4000 + 16'($urandom_range(0, 7) * 16);
        return addr_t'($urandom);
    endfunction

    // Present one request word and hold it until taken
    task automatic send_request(logic m, addr_t a, tag_t t);
        item_t w;
        w.mode        = m;
        w.req_address = a;
        w.req_tag     = t;
        start <= 1'b1;
        item  <= w;
        do @(posedge clk); while (busy);
        requests_sent++;
    endtask

    task automatic idle_gap(bit steady);
        int n;
        n = steady ? 0 : gap_len();
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every result word is back and the block is idle.
    // Polled on the falling edge so the monitor's update is already seen.
    task automatic wait_all_done();
        start <= 1'b0;
        do @(negedge clk); while (sb.outstanding() != 0 || busy);
        @(posedge clk);
    endtask

    // Policy only ever changes with the block idle
    task automatic change_policy(policy_t p);
        wait_all_done();
        cfg_valid <= 1'b1;
        cfg_data  <= p;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One burst of random traffic: a fill (adds only, may fill the table), a drain
    // (picks only, may go past empty), or a mix. Some bursts run with no gaps at all.
    task automatic run_segment();
        int   shape;
        int   n;
        int   add_pct;
        bit   steady;
        logic m;
        shape   = $urandom_range(0, 2);
        steady  = ($urandom_range(0, 3) == 0);
        add_pct = $urandom_range(30, 70);
        n       = (shape == 2) ? $urandom_range(10, 30) : $urandom_range(5, 36);
        for (int k = 0; k < n; k++)
        begin
            idle_gap(steady);
            if (shape == 0) m = MODE_ADD;
            else if (shape == 1) m = MODE_PICK;
            else m = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_PICK;
            send_request(m, pick_address(), tag_t'($urandom));
            // now and then let the block run dry before carrying on
            if ($urandom_range(0, 39) == 0) wait_all_done();
        end
    endtask

    initial
    begin
        int phase;
        int sel;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: FIFO from reset, empty pick, address and tag extremes, a tie
        send_request(MODE_PICK, 16'h0000, 8'h00);
        send_request(MODE_ADD,  16'h0000, 8'h00);
        send_request(MODE_ADD,  16'hFFFF, 8'hFF);
        send_request(MODE_ADD,  16'h8000, 8'h5A);
        send_request(MODE_ADD,  16'h8000, 8'hA5);
        send_request(MODE_PICK, 16'hFFFF, 8'hFF);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        // SSTF: two entries at the same distance, earlier arrival wins
        change_policy(POL_SSTF);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        // LOOK: carry on upward, then turn round
        change_policy(POL_LOOK);
        send_request(MODE_ADD,  16'h1000, 8'h11);
        send_request(MODE_ADD,  16'h9000, 8'h22);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        // CLOOK: nothing above the head, wrap to the lowest
        change_policy(POL_CLOOK);
        send_request(MODE_ADD,  16'h0200, 8'h33);
        send_request(MODE_ADD,  16'h0100, 8'h44);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        // FLOOK: active set empty, swap; a fresh add waits for the next swap
        change_policy(POL_FLOOK);
        send_request(MODE_ADD,  16'hFFFF, 8'h77);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        send_request(MODE_PICK, 16'h0000, 8'h00);
        // Spare code behaves as FIFO
        change_policy(POL_SPARE7);
        send_request(MODE_ADD,  16'h0001, 8'h01);
        send_request(MODE_PICK, 16'h0000, 8'h00);

        // Random phases: every code first, then mostly the real policies.
        // Table contents carry over from one phase to the next.
        phase = 0;
        while (requests_sent < ITEM_TARGET)
        begin
            if (phase < 8) sel = phase;
            else if ($urandom_range(0, 9) < 8) sel = $urandom_range(0, 4);
            else sel = $urandom_range(5, 7);
            change_policy(phase_policy[sel]);
            repeat ($urandom_range(2, 5)) run_segment();
            phase++;
        end

        wait_all_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("disk_request_scheduler: match");
        else
            $display("disk_request_scheduler: mismatch");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/drs_pkg.sv
rtl/drs_ram.sv
rtl/drs_scan.sv
rtl/disk_request_scheduler.sv
rtl/drs_checker.sv
bench/tb.sv
